[hdl/deq_pkg.sv]
package deq_pkg;

   // command codes on the request word
   localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
   localparam logic [2:0] CMD_DUMP_FWD   = 3'd2;
   localparam logic [2:0] CMD_COUNT      = 3'd3;
   localparam logic [2:0] CMD_DUMP_REV   = 3'd4;

   // status codes on the response word
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   localparam int ITEM_WIDTH  = 32;
   localparam int COUNT_WIDTH = 7;

   typedef struct packed {
      logic [2:0]                   command;
      logic signed [ITEM_WIDTH-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [ITEM_WIDTH-1:0] item;
      logic [COUNT_WIDTH-1:0]       count;
      logic [1:0]                   status;
      logic                         last;
   } rsp_type;

   // decoded operation handed from the front to the back
   typedef enum logic [2:0] {
      OP_PUSH_FRONT,
      OP_PUSH_BACK,
      OP_DUMP_FWD,
      OP_DUMP_REV,
      OP_COUNT
   } op_type;

   typedef struct packed {
      logic   valid;
      op_type op;
   } cmd_type;

endpackage

[hdl/deq_fifo.sv]
module deq_fifo import deq_pkg::*; #(
   parameter type T     = logic,
   parameter int  DEPTH = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  T                           wr_data,
   output logic                       full,
   input  logic                       pop,
   output T                           rd_data,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] level
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LW = $clog2(DEPTH+1);

   T               data_ff [DEPTH];
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [LW-1:0]  level_ff, level_in;
   logic           do_push, do_pop;

   assign full    = (level_ff == LW'(DEPTH));
   assign empty   = (level_ff == '0);
   assign level   = level_ff;
   assign rd_data = data_ff[rd_ptr_ff];
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         level_in = level_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

[hdl/deq_front.sv]
module deq_front import deq_pkg::*; #(
   parameter int DATA_WIDTH = 32,
   parameter int CMD_DEPTH  = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  req_type               req_word,
   output logic                  req_full,
   output cmd_type               cmd,
   output logic [DATA_WIDTH-1:0] cmd_data,
   input  logic                  cmd_pop
);

   typedef struct packed {
      op_type                op;
      logic [DATA_WIDTH-1:0] data;
   } entry_type;

   entry_type  wr_entry, rd_entry;
   logic       code_ok;
   logic       q_empty;
   logic signed [63:0] value_wide;

   assign value_wide = 64'(req_word.value);

   always_comb begin
      // words are kept as the low bits of the sign-extended value
      wr_entry.data = value_wide[DATA_WIDTH-1:0];
      code_ok       = 1'b1;
      wr_entry.op   = OP_COUNT;
      case (req_word.command)
         CMD_PUSH_FRONT: wr_entry.op = OP_PUSH_FRONT;
         CMD_PUSH_BACK:  wr_entry.op = OP_PUSH_BACK;
         CMD_DUMP_FWD:   wr_entry.op = OP_DUMP_FWD;
         CMD_DUMP_REV:   wr_entry.op = OP_DUMP_REV;
         CMD_COUNT:      wr_entry.op = OP_COUNT;
         default:        code_ok     = 1'b0;
      endcase
   end

   // unused codes are taken and dropped here
   deq_fifo #(
      .T     (entry_type),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_q (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push & code_ok),
      .wr_data (wr_entry),
      .full    (req_full),
      .pop     (cmd_pop),
      .rd_data (rd_entry),
      .empty   (q_empty),
      .level   ()
   );

   assign cmd.valid = ~q_empty;
   assign cmd.op    = rd_entry.op;
   assign cmd_data  = rd_entry.data;

endmodule

[hdl/deq_back.sv]
module deq_back import deq_pkg::*; #(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 32,
   parameter int OUT_DEPTH  = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   input  logic [DATA_WIDTH-1:0] cmd_data,
   output logic                  cmd_pop,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output rsp_type               rsp_word
);

   localparam int IW = $clog2(DEPTH);
   localparam int HW = $clog2(DEPTH+1);
   localparam int OW = $clog2(OUT_DEPTH+1);

   typedef enum logic {
      S_IDLE,
      S_DUMP
   } state_type;

   state_type             state_ff, state_in;
   logic [IW-1:0]         head_ff, head_in;
   logic [HW-1:0]         held_ff, held_in;
   logic [IW-1:0]         off_ff, off_in;
   logic [HW-1:0]         remain_ff, remain_in;
   logic                  fwd_ff, fwd_in;

   // result stage behind the memory read
   logic                  b_valid_ff, b_valid_in;
   logic                  b_mem_ff, b_mem_in;
   logic [COUNT_WIDTH-1:0] b_count_ff, b_count_in;
   logic [1:0]            b_status_ff, b_status_in;
   logic                  b_last_ff, b_last_in;

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;
   logic                  wr_en, rd_en;
   logic [IW-1:0]         wr_addr, rd_addr;
   logic [IW:0]           addr_sum;
   logic [IW:0]           back_sum;
   logic                  is_full;
   logic                  space;
   logic [OW-1:0]         out_level;
   logic                  out_full;
   rsp_type               b_word;
   logic signed [63:0]    rd_wide;

   assign is_full = (held_ff == HW'(DEPTH));
   assign space   = (32'(out_level) + 32'(b_valid_ff)) < OUT_DEPTH;

   // ring addressing, sums stay below twice the depth
   always_comb begin
      addr_sum = {1'b0, head_ff} + {1'b0, off_ff};
      if (addr_sum >= (IW+1)'(DEPTH)) begin
         addr_sum = addr_sum - (IW+1)'(DEPTH);
      end
      back_sum = {1'b0, head_ff} + {1'b0, IW'(held_ff)};
      if (back_sum >= (IW+1)'(DEPTH)) begin
         back_sum = back_sum - (IW+1)'(DEPTH);
      end
   end

   assign rd_addr = addr_sum[IW-1:0];

   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      held_in     = held_ff;
      off_in      = off_ff;
      remain_in   = remain_ff;
      fwd_in      = fwd_ff;
      b_valid_in  = 1'b0;
      b_mem_in    = 1'b0;
      b_count_in  = COUNT_WIDTH'(held_ff);
      b_status_in = ST_OK;
      b_last_in   = 1'b1;
      cmd_pop     = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = back_sum[IW-1:0];
      rd_en       = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (cmd.valid && space) begin
               cmd_pop    = 1'b1;
               b_valid_in = 1'b1;
               case (cmd.op)
                  OP_PUSH_FRONT, OP_PUSH_BACK: begin
                     if (is_full) begin
                        b_status_in = ST_FULL;
                     end else begin
                        wr_en      = 1'b1;
                        held_in    = held_ff + 1'b1;
                        b_count_in = COUNT_WIDTH'(held_ff + 1'b1);
                        if (cmd.op == OP_PUSH_FRONT) begin
                           head_in = (head_ff == '0) ? IW'(DEPTH-1) : head_ff - 1'b1;
                           wr_addr = head_in;
                        end
                     end
                  end
                  OP_DUMP_FWD, OP_DUMP_REV: begin
                     if (held_ff == '0) begin
                        b_status_in = ST_EMPTY;
                     end else begin
                        b_valid_in = 1'b0;
                        state_in   = S_DUMP;
                        fwd_in     = (cmd.op == OP_DUMP_FWD);
                        off_in     = (cmd.op == OP_DUMP_FWD) ? '0 : IW'(held_ff - 1'b1);
                        remain_in  = held_ff;
                     end
                  end
                  default: begin
                     // count reports the current fill
                  end
               endcase
            end
         end
         S_DUMP: begin
            if (space) begin
               rd_en      = 1'b1;
               b_valid_in = 1'b1;
               b_mem_in   = 1'b1;
               b_last_in  = (remain_ff == HW'(1));
               remain_in  = remain_ff - 1'b1;
               off_in     = fwd_ff ? off_ff + 1'b1 : off_ff - 1'b1;
               if (remain_ff == HW'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         head_ff    <= '0;
         held_ff    <= '0;
         b_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         head_ff    <= head_in;
         held_ff    <= held_in;
         b_valid_ff <= b_valid_in;
      end
      off_ff      <= off_in;
      remain_ff   <= remain_in;
      fwd_ff      <= fwd_in;
      b_mem_ff    <= b_mem_in;
      b_count_ff  <= b_count_in;
      b_status_ff <= b_status_in;
      b_last_ff   <= b_last_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= cmd_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // stored words come out sign-extended from the data width
   assign rd_wide        = 64'(signed'(rd_data_ff));
   assign b_word.item    = b_mem_ff ? rd_wide[ITEM_WIDTH-1:0] : '0;
   assign b_word.count   = b_count_ff;
   assign b_word.status  = b_status_ff;
   assign b_word.last    = b_last_ff;

   deq_fifo #(
      .T     (rsp_type),
      .DEPTH (OUT_DEPTH)
   ) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .push    (b_valid_ff),
      .wr_data (b_word),
      .full    (out_full),
      .pop     (rsp_pop),
      .rd_data (rsp_word),
      .empty   (rsp_empty),
      .level   (out_level)
   );

   a_held_range: assert property (@(posedge clock) disable iff (reset)
      held_ff <= HW'(DEPTH))
      else $error("fill above depth");

   a_dump_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DUMP) |-> (held_ff != '0) && (remain_ff != '0))
      else $error("dump running on an empty queue");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff |-> !out_full)
      else $error("result queue overrun");

   a_dump_holds_cmd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DUMP) |-> !cmd_pop && !wr_en)
      else $error("command taken during a dump");

endmodule

[hdl/double_ended_queue.sv]
// bounded double-ended queue of signed words, held in a DEPTH-entry ring
// buffer. a request word carries a command and a value: push front and push
// back each answer with one status word (status full and nothing stored when
// the queue already holds DEPTH words), count answers with the fill, and dump
// forward / dump reverse stream every held word front to back or back to
// front, last set on the final one; a dump of an empty queue answers once
// with status empty. unused command codes are taken and dropped without a
// response. words are stored as their low DATA_WIDTH bits and come back
// sign-extended to 32 bits. the execution unit takes a push or count at one
// word per cycle while the result queue has room; a dump reads its words
// out of the single read port of the ring memory and holds the unit until
// its last word is read. response words pass through the execution unit's
// result registers into the result queue; a dump's words also pass through
// a registered memory read. the request side has a two-entry command queue
// and the response side a four-entry result queue, so either side may stall
// until its queue fills without the other waiting on it.
module double_ended_queue import deq_pkg::*; #(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic    clock,
   input  logic    reset,
   // request channel
   input  logic    req_push,
   input  req_type req_word,
   output logic    req_full,
   // response channel
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_word
);

   cmd_type               cmd;
   logic [DATA_WIDTH-1:0] cmd_data;
   logic                  cmd_pop;

   // front: decodes the command and queues it with the converted word
   deq_front #(
      .DATA_WIDTH (DATA_WIDTH),
      .CMD_DEPTH  (2)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_word (req_word),
      .req_full (req_full),
      .cmd      (cmd),
      .cmd_data (cmd_data),
      .cmd_pop  (cmd_pop)
   );

   // back: owns the ring memory, head and fill, and walks dumps word by word
   deq_back #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH),
      .OUT_DEPTH  (4)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_word  (rsp_word)
   );

endmodule

[tb/sv/double_ended_queue_tb.sv]
module double_ended_queue_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import deq_pkg::*;

   localparam int QUEUE_DEPTH  = 64;
   localparam int WORD_BITS    = 32;
   // request words that carry a real command in the random part
   localparam int RANDOM_WORDS = 160;
   // response side hold-off, long enough to back the block up into req_full
   localparam int HOLD_CYCLES  = 300;
   // quiet cycles after the last expected word, to catch stray responses
   localparam int DRAIN_CYCLES = 20;
   // command codes the block takes and drops without a response
   localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
   localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

   // shadow copy of the deque plus the words it still owes us
   class deque_checker;
      logic signed [WORD_BITS-1:0] ring [QUEUE_DEPTH];
      int head;
      int fill;
      rsp_type due_words [$];
      int requests;
      int words_seen;
      int mismatches;
      int full_pushes;
      int empty_dumps;

      function new();
         head = 0;
         fill = 0;
         requests = 0;
         words_seen = 0;
         mismatches = 0;
         full_pushes = 0;
         empty_dumps = 0;
      endfunction

      function void queue_word(logic signed [WORD_BITS-1:0] item, logic [1:0] status,
                               logic last);
         rsp_type w;
         w.item = item;
         w.count = COUNT_WIDTH'(fill);
         w.status = status;
         w.last = last;
         due_words.push_back(w);
      endfunction

      // update the shadow for one accepted request and queue what it owes
      function void note_request(req_type w);
         int slot;
         int pos;
         int offset;
         requests++;
         case (w.command)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
               if (fill >= QUEUE_DEPTH) begin
                  // no room, word dropped
                  full_pushes++;
                  queue_word('0, ST_FULL, 1'b1);
               end else begin
                  if (w.command == CMD_PUSH_FRONT) begin
                     head = (head == 0) ? QUEUE_DEPTH - 1 : head - 1;
                     slot = head;
                  end else begin
                     slot = (head + fill) % QUEUE_DEPTH;
                  end
                  ring[slot] = w.value;
                  fill++;
                  queue_word('0, ST_OK, 1'b1);
               end
            end
            CMD_COUNT: queue_word('0, ST_OK, 1'b1);
            CMD_DUMP_FWD, CMD_DUMP_REV: begin
               if (fill == 0) begin
                  empty_dumps++;
                  queue_word('0, ST_EMPTY, 1'b1);
               end else begin
                  for (pos = 0; pos < fill; pos++) begin
                     offset = (w.command == CMD_DUMP_FWD) ? pos : fill - 1 - pos;
                     queue_word(ring[(head + offset) % QUEUE_DEPTH], ST_OK,
                                pos == fill - 1);
                  end
               end
            end
            default: ;
         endcase
      endfunction

      task report_mismatch(string msg);
         mismatches++;
         if (mismatches <= 40)
            $display("mismatch at %0t ns: %s", $time, msg);
      endtask

      task check_word(rsp_type got);
         rsp_type want;
         words_seen++;
         if (due_words.size() == 0) begin
            report_mismatch($sformatf("word %0d not expected: item %0d count %0d status %0d last %0d",
                                      words_seen, got.item, got.count, got.status, got.last));
            return;
         end
         want = due_words.pop_front();
         if (got.item !== want.item)
            report_mismatch($sformatf("word %0d item %0d, want %0d",
                                      words_seen, got.item, want.item));
         if (got.count !== want.count)
            report_mismatch($sformatf("word %0d count %0d, want %0d",
                                      words_seen, got.count, want.count));
         if (got.status !== want.status)
            report_mismatch($sformatf("word %0d status %0d, want %0d",
                                      words_seen, got.status, want.status));
         if (got.last !== want.last)
            report_mismatch($sformatf("word %0d last %0b, want %0b",
                                      words_seen, got.last, want.last));
      endtask
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   req_type req_word = '0;
   logic    req_full;
   logic    rsp_empty;
   logic    rsp_pop = 1'b0;
   rsp_type rsp_word;

   deque_checker shadow = new();

   // request side idle state and back-pressure tally
   int send_calm = 0;
   int full_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   double_ended_queue #(
      .DEPTH      (QUEUE_DEPTH),
      .DATA_WIDTH (WORD_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_word  (req_word),
      .req_full  (req_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_word  (rsp_word)
   );

   // idle length: mostly none, some short, a few long, with calm stretches
   function automatic int pick_gap(inout int calm_left);
      int roll;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      roll = $urandom_range(99);
      if (roll < 4) begin
         calm_left = $urandom_range(60, 20);
         return 0;
      end
      if (roll < 70)
         return 0;
      if (roll < 95)
         return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   // push-heavy mix so the deque grows to full partway through the run
   function automatic logic [2:0] pick_command();
      int roll;
      roll = $urandom_range(99);
      if (roll < 28) return CMD_PUSH_FRONT;
      if (roll < 56) return CMD_PUSH_BACK;
      if (roll < 68) return CMD_DUMP_FWD;
      if (roll < 80) return CMD_DUMP_REV;
      if (roll < 92) return CMD_COUNT;
      return 3'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
   endfunction

   // data word with extra weight on the signed extremes
   function automatic logic signed [WORD_BITS-1:0] pick_value();
      case ($urandom_range(9))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return '0;
         3: return '1;
         default: return $urandom;
      endcase
   endfunction

   // offer one request word, hold it until taken, then maybe idle
   task automatic send_word(input logic [2:0] command,
                            input logic signed [WORD_BITS-1:0] value);
      req_type w;
      int gap;
      w.command = command;
      w.value = value;
      req_push <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (req_full) begin
         full_cycles++;
         @(posedge clock);
      end
      // taken at this edge
      shadow.note_request(w);
      gap = pick_gap(send_calm);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // response side: check every popped word, stall at random, and twice
   // hold off for a long stretch so the block backs up into req_full
   initial begin : rsp_side
      int hold_left;
      int gap_left;
      int rsp_calm;
      hold_left = 0;
      gap_left = 0;
      rsp_calm = 0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_pop && !rsp_empty) begin
            shadow.check_word(rsp_word);
            if (shadow.words_seen == 40 || shadow.words_seen == 600)
               hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (gap_left > 0) begin
            gap_left--;
            rsp_pop <= 1'b0;
         end else begin
            gap_left = pick_gap(rsp_calm);
            rsp_pop <= (gap_left == 0);
         end
      end
   end

   // stimulus
   initial begin : req_side
      int sent;
      int code;
      logic [2:0] command;
      bit drained;
      sent = 0;
      drained = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // empty queue: count reports zero and both dumps flag empty
      send_word(CMD_COUNT, pick_value());
      send_word(CMD_DUMP_FWD, pick_value());
      send_word(CMD_DUMP_REV, pick_value());
      // unused codes are swallowed with no response
      for (code = CMD_SPARE_FIRST; code <= CMD_SPARE_LAST; code++)
         send_word(3'(code), pick_value());
      // extremes of the data word at both ends
      send_word(CMD_PUSH_FRONT, 32'h7fff_ffff);
      send_word(CMD_PUSH_BACK, 32'h8000_0000);
      send_word(CMD_PUSH_FRONT, 32'h0000_0000);
      send_word(CMD_PUSH_BACK, 32'hffff_ffff);
      send_word(CMD_PUSH_FRONT, 32'h5555_5555);
      send_word(CMD_PUSH_BACK, 32'haaaa_aaaa);
      send_word(CMD_DUMP_FWD, pick_value());
      send_word(CMD_DUMP_REV, pick_value());
      send_word(CMD_COUNT, pick_value());

      // random mix; the deque fills and then every push is dropped full
      while (sent < RANDOM_WORDS) begin
         command = pick_command();
         send_word(command, pick_value());
         if (command < CMD_SPARE_FIRST)
            sent++;
         // halfway: go quiet until every owed word has come back
         if (!drained && sent == RANDOM_WORDS / 2) begin
            drained = 1'b1;
            req_push <= 1'b0;
            while (shadow.due_words.size() != 0) @(posedge clock);
         end
      end
      req_push <= 1'b0;

      while (shadow.due_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d requests and %0d response words, final fill %0d of %0d",
               shadow.requests, shadow.words_seen, shadow.fill, QUEUE_DEPTH);
      $display("dropped full pushes %0d, empty dumps %0d, request stall cycles %0d",
               shadow.full_pushes, shadow.empty_dumps, full_cycles);
      if (shadow.mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin : watchdog
      #20ms;
      $display("run did not finish in time");
      $display("TB_ERROR");
      $finish;
   end

endmodule
